// ----- hw/rtl/f2pcm_pkg.sv -----
// Package for the float32 to int16 PCM converter.
// Holds the pipeline record between multiply and round stages and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
package f2pcm_pkg;

  localparam logic [14:0] PCM_SCALE = 15'd32767;
  localparam logic signed [15:0] PCM_MAX = 16'sd32767;
  localparam logic signed [15:0] PCM_MIN = -16'sd32768;
  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_ZERO = 8'h00;
  // right shift applied to the rounded significand is SHIFT_BASE + norm - exponent
  localparam logic signed [9:0] SHIFT_BASE = 10'sd135;
  localparam logic signed [9:0] SHIFT_SAT = 10'sd8;
  localparam logic signed [9:0] SHIFT_ZERO = 10'sd26;
  localparam logic [16:0] MAG_MAX = 17'd32767;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic        sign;
    logic        nan;
    logic [7:0]  exp;
    logic [38:0] p;
  } prod_t;

endpackage

// ----- hw/rtl/f2pcm_mul.sv -----
// Input register and significand multiply by 32767.
// Depends on f2pcm_pkg.
`timescale 1ns / 1ps
module f2pcm_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [31:0]       float_bits,
  input  logic              last_in,
  output f2pcm_pkg::prod_t  prod
);
  import f2pcm_pkg::*;

  logic        a_valid;
  logic [31:0] a_bits;
  logic        a_last;
  logic [23:0] mant;
  prod_t       prod_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_bits <= float_bits;
    a_last <= last_in;
  end

  always_comb begin
    mant = {1'b1, a_bits[22:0]};
    prod_next.valid = a_valid;
    prod_next.last = a_last;
    prod_next.sign = a_bits[31];
    prod_next.exp = a_bits[30:23];
    prod_next.nan = (a_bits[30:23] == EXP_ALL_ONES) && (a_bits[22:0] != 23'd0);
    prod_next.p = 39'(mant) * 39'(PCM_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else begin
      prod.valid <= prod_next.valid;
    end
    prod.last <= prod_next.last;
    prod.sign <= prod_next.sign;
    prod.nan <= prod_next.nan;
    prod.exp <= prod_next.exp;
    prod.p <= prod_next.p;
  end

endmodule

// ----- hw/rtl/f2pcm_round.sv -----
// Single-precision rounding of the product, integer rounding and saturation.
// Depends on f2pcm_pkg.
`timescale 1ns / 1ps
module f2pcm_round (
  input  logic                    clk,
  input  logic                    rst,
  input  f2pcm_pkg::prod_t        prod,
  output logic                    done,
  output logic signed [15:0]      pcm_value,
  output logic                    last_out
);
  import f2pcm_pkg::*;

  logic               hi;
  logic [23:0]        sig24;
  logic               guard;
  logic               sticky;
  logic               inc;
  logic [24:0]        s;
  logic signed [9:0]  shamt;
  logic [4:0]         shv;
  logic [24:0]        q;
  logic               half;
  logic [16:0]        mag;
  logic signed [15:0] pcm_next;

  always_comb begin
    hi = prod.p[38];
    sig24 = hi ? prod.p[38:15] : prod.p[37:14];
    guard = hi ? prod.p[14] : prod.p[13];
    sticky = hi ? (|prod.p[13:0]) : (|prod.p[12:0]);
    inc = guard & (sticky | sig24[0]);
    s = {1'b0, sig24} + 25'(inc);
    shamt = SHIFT_BASE + $signed({9'd0, ~hi}) - $signed({2'd0, prod.exp});
    shv = shamt[4:0];
    q = s >> shv;
    half = s[5'(shv - 5'd1)];
    mag = q[16:0] + 17'(half);
    if (prod.nan || prod.exp == EXP_ZERO) begin
      pcm_next = 16'sd0;
    end else if (prod.exp == EXP_ALL_ONES || shamt <= SHIFT_SAT) begin
      pcm_next = prod.sign ? PCM_MIN : PCM_MAX;
    end else if (shamt >= SHIFT_ZERO) begin
      pcm_next = 16'sd0;
    end else if (prod.sign) begin
      pcm_next = (mag > MAG_MAX) ? PCM_MIN : -$signed(mag[15:0]);
    end else begin
      pcm_next = (mag > MAG_MAX) ? PCM_MAX : $signed(mag[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod.valid;
    end
    pcm_value <= pcm_next;
    last_out <= prod.last;
  end

endmodule

// ----- hw/rtl/float32_to_int16_pcm_saturating_unit.sv -----
// Converts one float32 sample per clock to a saturated int16 PCM sample.
// Pipeline: input register, 24x15 multiply stage (f2pcm_mul), rounding stage
// (f2pcm_round). A new sample is taken every cycle; busy is always low and
// done marks each result after the multiply and rounding stages, in start order.
// The receiver cannot stall, so the result is valid for that cycle only.
// NaN gives 0, infinities saturate. Depends on f2pcm_pkg.
`timescale 1ns / 1ps
module float32_to_int16_pcm_saturating_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        float_bits,
  input  logic               last_in,
  output logic               done,
  output logic signed [15:0] pcm_value,
  output logic               last_out
);
  import f2pcm_pkg::*;

  prod_t prod;

  assign busy = 1'b0;

  f2pcm_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start),
    .float_bits (float_bits),
    .last_in    (last_in),
    .prod       (prod)
  );

  f2pcm_round u_round (
    .clk       (clk),
    .rst       (rst),
    .prod      (prod),
    .done      (done),
    .pcm_value (pcm_value),
    .last_out  (last_out)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##3 done)
    else $error("missing result beat");

  a_last: assert property (@(posedge clk) disable iff (rst)
    start |-> ##3 (last_out == $past(last_in, 3)))
    else $error("last flag mismatch");

  a_nan: assert property (@(posedge clk) disable iff (rst)
    (start && float_bits[30:23] == 8'hFF && float_bits[22:0] != 23'd0)
      |-> ##3 (pcm_value == 16'sd0))
    else $error("NaN not zero");

  a_pinf: assert property (@(posedge clk) disable iff (rst)
    (start && float_bits == 32'h7F80_0000) |-> ##3 (pcm_value == PCM_MAX))
    else $error("+inf not saturated");

endmodule
